// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("assert");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("assert");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ----- rtl/skt_pkg.sv -----
// Package: types and constants of the sorted key table.
package skt_pkg;
  localparam int DepthDef = 256;
  localparam int KeyBytesDef = 8;
  localparam int ValueBitsDef = 32;

  typedef enum logic [1:0] {
    CMD_FIND = 2'd0, CMD_INSERT = 2'd1, CMD_DELETE = 2'd2, CMD_FIND3 = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NOT_FOUND = 2'd1, ST_DUPLICATE = 2'd2, ST_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_SRCH_WAIT, S_CHECK, S_CHECK_WAIT, S_SHIFT, S_SHIFT_WAIT, S_DONE
  } state_t;
endpackage

// ----- rtl/skt_if.sv -----
// Valid/ready channel interfaces for commands and results.
interface skt_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] lookup_key;
  logic [31:0] entry_value;
  modport source (output valid, cmd, lookup_key, entry_value, input ready);
  modport sink (input valid, cmd, lookup_key, entry_value, output ready);
endinterface

interface skt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_value;
  logic [7:0]  position;
  logic [8:0]  entry_count;
  modport source (output valid, status, found_value, position, entry_count, input ready);
  modport sink (input valid, status, found_value, position, entry_count, output ready);
endinterface

// ----- rtl/sorted_key_table.sv -----
// Each command runs a binary search of S steps (S_SRCH, S_SRCH_WAIT), S at most
// $clog2(DEPTH+1), then a check of the entry at lo, the shift and S_DONE; insert and
// delete move one shifted entry per S_SHIFT/S_SHIFT_WAIT pair. One word in flight: the
// next command is accepted in S_IDLE, once the result word is registered.
// A result not yet taken holds the next one back; search and shift share one read port.
// Reset (rst, synchronous) empties the table; memory contents are not cleared.
`include "assert_macros.svh"
module sorted_key_table import skt_pkg::*; #(
  parameter int DEPTH = DepthDef,
  parameter int KEY_BYTES = KeyBytesDef,
  parameter int VALUE_BITS = ValueBitsDef
) (
  input logic clk,
  input logic rst,
  skt_cmd_if.sink in_ch,
  skt_rsp_if.source out_ch
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = 8 * KEY_BYTES;

  // Key and value memories, one read and one write port each.
  logic [KW-1:0]         key_mem [DEPTH];
  logic [VALUE_BITS-1:0] val_mem [DEPTH];
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [KW-1:0] wr_key, rd_key;
  logic [VALUE_BITS-1:0] wr_val, rd_val;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    rd_key <= key_mem[rd_addr];
    rd_val <= val_mem[rd_addr];
  end

  state_t state, state_next;
  cmd_t   cmd;
  logic [KW-1:0] key;
  logic [VALUE_BITS-1:0] val;
  logic [CW-1:0] count, lo, hi, idx;  // idx walks the shift
  logic [CW-1:0] idx_m1;
  logic [AW-1:0] mid;
  logic          hit;
  logic [1:0]    status;
  logic [31:0]   fval;
  logic [7:0]    pos;
  logic          out_valid;

  logic [CW:0] sum;
  assign sum = {1'b0, lo} + {1'b0, hi};
  assign idx_m1 = idx - CW'(1);

  // rd_key holds the entry at lo while in S_CHECK_WAIT.
  assign hit = (lo < count) && (rd_key == key);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (in_ch.valid) state_next = S_SRCH;
      S_SRCH:       state_next = (lo < hi) ? S_SRCH_WAIT : S_CHECK;
      S_SRCH_WAIT:  state_next = S_SRCH;
      S_CHECK:      state_next = S_CHECK_WAIT;
      S_CHECK_WAIT: state_next = S_SHIFT;
      S_SHIFT: begin
        // Another entry to move, or the shift is over.
        if (cmd == CMD_INSERT && status == ST_OK && idx > lo) state_next = S_SHIFT_WAIT;
        else if (cmd == CMD_DELETE && status == ST_OK && idx < count) state_next = S_SHIFT_WAIT;
        else state_next = S_DONE;
      end
      S_SHIFT_WAIT: state_next = S_SHIFT;
      S_DONE:       if (!out_valid || out_ch.ready) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // Insert reads idx-1 and writes it to idx, walking down to lo;
  // delete reads idx and writes it to idx-1, walking up to count.
  always_comb begin
    wr_en = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_key = rd_key;
    wr_val = rd_val;
    if (state == S_SHIFT_WAIT) begin
      wr_en = 1'b1;
      wr_addr = (cmd == CMD_INSERT) ? idx[AW-1:0] : idx_m1[AW-1:0];
    end else if (state == S_SHIFT && cmd == CMD_INSERT && status == ST_OK && idx <= lo) begin
      wr_en = 1'b1;
      wr_addr = lo[AW-1:0];
      wr_key = key;
      wr_val = val;
    end
  end

  assign in_ch.ready = (state == S_IDLE);
  assign rd_addr = (state == S_SRCH) ? mid :
                   (state == S_CHECK) ? lo[AW-1:0] :
                   (cmd == CMD_INSERT) ? idx_m1[AW-1:0] : idx[AW-1:0];
  assign mid = sum[AW:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          cmd <= cmd_t'(in_ch.cmd);
          key <= in_ch.lookup_key[KW-1:0];
          val <= VALUE_BITS'(in_ch.entry_value);
          lo <= '0;
          hi <= count;
        end
        S_SRCH_WAIT: begin
          if (rd_key < key) lo <= CW'(sum[CW:1]) + CW'(1);
          else hi <= CW'(sum[CW:1]);
        end
        S_CHECK_WAIT: begin
          if (cmd == CMD_INSERT) begin
            fval <= '0;
            idx <= count;
            if (hit) begin
              status <= ST_DUPLICATE; pos <= 8'(lo);
            end else if (count == CW'(DEPTH)) begin
              status <= ST_FULL; pos <= '0;
            end else begin
              status <= ST_OK; pos <= 8'(lo);
            end
          end else begin
            idx <= lo + CW'(1);
            if (hit) begin
              status <= ST_OK; fval <= 32'(rd_val); pos <= 8'(lo);
            end else begin
              status <= ST_NOT_FOUND; fval <= '0; pos <= '0;
            end
          end
        end
        S_SHIFT: if (state_next == S_DONE && status == ST_OK) begin
          if (cmd == CMD_INSERT) count <= count + CW'(1);
          else if (cmd == CMD_DELETE) count <= count - CW'(1);
        end
        S_SHIFT_WAIT: begin
          if (cmd == CMD_INSERT) idx <= idx_m1;
          else idx <= idx + CW'(1);
        end
        default: ;
      endcase
      // Result register: loads when free or being emptied in the same cycle.
      if (state == S_DONE && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
        out_ch.status <= status;
        out_ch.found_value <= fval;
        out_ch.position <= pos;
        out_ch.entry_count <= 9'(count);
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid;

  `ASSERT_IMPLIES(a_count_range, clk, rst, 1'b1, count <= CW'(DEPTH))
  `ASSERT_IMPLIES(a_ready_idle, clk, rst, in_ch.ready, state == S_IDLE)
  `ASSERT_IMPLIES(a_search_bounds, clk, rst, state == S_SRCH, lo <= hi && hi <= count)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ch.ready, out_valid)
endmodule
